### hdl/segi_pkg.sv
// shared widths and sideband types for the segment intersection pipeline
package segi_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 16;
    localparam int OUT_WIDTH   = 32;

    // difference, product, cross product and numerator widths
    localparam int DW  = COORD_WIDTH + 1;
    localparam int PW  = 2 * DW;
    localparam int CRW = PW + 1;
    localparam int NW  = DW + CRW;
    // remainder width (denominator magnitude fits unsigned in CRW bits)
    localparam int RW  = CRW;
    // quotient bits: |d1.x| < 2^COORD_WIDTH so quotient < 2^(COORD_WIDTH+FRAC_BITS)
    localparam int QW  = COORD_WIDTH + FRAC_BITS;
    localparam int SUMW = (QW + 2 > OUT_WIDTH) ? QW + 2 : OUT_WIDTH;

    // sideband word that rides alongside the dividers
    typedef struct packed {
        logic                          found;
        logic                          overlap;
        logic                          neg_x;
        logic                          neg_y;
        logic signed [COORD_WIDTH-1:0] s1x;
        logic signed [COORD_WIDTH-1:0] s1y;
        logic signed [COORD_WIDTH-1:0] s2x;
        logic signed [COORD_WIDTH-1:0] s2y;
    } t_side;

endpackage

### hdl/segi_div.sv
// pipelined restoring divider, one quotient bit per stage
module segi_div (
    input  logic                   i_clk,
    input  logic [segi_pkg::NW-1:0] i_mag,
    input  logic [segi_pkg::RW-1:0] i_den,
    output logic [segi_pkg::QW-1:0] o_quot,
    output logic                   o_rem_nz
);
    import segi_pkg::*;

    logic [RW-1:0] r_rem [QW];
    logic [RW-1:0] r_den [QW];
    logic [QW-1:0] r_low [QW];
    logic [QW-1:0] r_quo [QW];

    // preload: high part of the scaled dividend is already below the divisor
    logic [NW-1:0] w_hi;
    logic [QW-1:0] w_low0;
    assign w_hi   = i_mag >> COORD_WIDTH;
    assign w_low0 = QW'(i_mag[COORD_WIDTH-1:0]) << FRAC_BITS;

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            logic [RW-1:0] w_rem_in;
            logic [RW-1:0] w_den_in;
            logic [QW-1:0] w_low_in;
            logic [QW-1:0] w_quo_in;
            logic [RW:0]   w_try;
            logic          w_ge;

            if (k == 0) begin : g_first
                assign w_rem_in = w_hi[RW-1:0];
                assign w_den_in = i_den;
                assign w_low_in = w_low0;
                assign w_quo_in = '0;
            end else begin : g_next
                assign w_rem_in = r_rem[k-1];
                assign w_den_in = r_den[k-1];
                assign w_low_in = r_low[k-1];
                assign w_quo_in = r_quo[k-1];
            end

            // shift in next dividend bit and try the subtract
            assign w_try = {w_rem_in, w_low_in[QW-1]};
            assign w_ge  = (w_try >= {1'b0, w_den_in});

            always_ff @(posedge i_clk) begin
                r_rem[k] <= w_ge ? RW'(w_try - {1'b0, w_den_in}) : w_try[RW-1:0];
                r_den[k] <= w_den_in;
                r_low[k] <= {w_low_in[QW-2:0], 1'b0};
                r_quo[k] <= {w_quo_in[QW-2:0], w_ge};
            end
        end
    endgenerate

    assign o_quot   = r_quo[QW-1];
    assign o_rem_nz = (r_rem[QW-1] != '0);

endmodule

### hdl/segment_intersection_top.sv
// segment intersection top level: ordering, cross products, division, fixed point result
// pipeline: 7 front stages, 32 divider stages and an output stage from start to o_done
// throughput: one segment pair per cycle, busy is never raised
// the dividers retire one quotient bit per stage and set the depth
// reset clears only the valid bits; data registers are not reset
// the receiver cannot stall, every result is shown for one cycle
module segment_intersection_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [segi_pkg::COORD_WIDTH-1:0] i_seg1_start_x,
    input  logic signed [segi_pkg::COORD_WIDTH-1:0] i_seg1_start_y,
    input  logic signed [segi_pkg::COORD_WIDTH-1:0] i_seg1_end_x,
    input  logic signed [segi_pkg::COORD_WIDTH-1:0] i_seg1_end_y,
    input  logic signed [segi_pkg::COORD_WIDTH-1:0] i_seg2_start_x,
    input  logic signed [segi_pkg::COORD_WIDTH-1:0] i_seg2_start_y,
    input  logic signed [segi_pkg::COORD_WIDTH-1:0] i_seg2_end_x,
    input  logic signed [segi_pkg::COORD_WIDTH-1:0] i_seg2_end_y,
    output logic                                  o_done,
    output logic                                  o_found,
    output logic                                  o_overlap,
    output logic signed [segi_pkg::OUT_WIDTH-1:0]   o_point_x,
    output logic signed [segi_pkg::OUT_WIDTH-1:0]   o_point_y
);
    import segi_pkg::*;

    localparam int CW = COORD_WIDTH;

    assign busy = 1'b0;

    function automatic logic lex_le(input logic signed [CW-1:0] ax, input logic signed [CW-1:0] ay,
                                    input logic signed [CW-1:0] bx, input logic signed [CW-1:0] by);
        lex_le = (ax < bx) || ((ax == bx) && (ay <= by));
    endfunction

    // valid bits of the front stages
    logic [6:0] r_v;

    // stage 1: endpoint and segment ordering
    logic signed [CW-1:0] w_a1x, w_a1y, w_b1x, w_b1y, w_a2x, w_a2y, w_b2x, w_b2y;
    logic                 w_sw;
    logic signed [CW-1:0] r_s1x, r_s1y, r_e1x, r_e1y, r_s2x, r_s2y, r_e2x, r_e2y;

    always_comb begin
        if (lex_le(i_seg1_start_x, i_seg1_start_y, i_seg1_end_x, i_seg1_end_y)) begin
            w_a1x = i_seg1_start_x; w_a1y = i_seg1_start_y;
            w_b1x = i_seg1_end_x;   w_b1y = i_seg1_end_y;
        end else begin
            w_a1x = i_seg1_end_x;   w_a1y = i_seg1_end_y;
            w_b1x = i_seg1_start_x; w_b1y = i_seg1_start_y;
        end
        if (lex_le(i_seg2_start_x, i_seg2_start_y, i_seg2_end_x, i_seg2_end_y)) begin
            w_a2x = i_seg2_start_x; w_a2y = i_seg2_start_y;
            w_b2x = i_seg2_end_x;   w_b2y = i_seg2_end_y;
        end else begin
            w_a2x = i_seg2_end_x;   w_a2y = i_seg2_end_y;
            w_b2x = i_seg2_start_x; w_b2y = i_seg2_start_y;
        end
        w_sw = !lex_le(w_a1x, w_a1y, w_a2x, w_a2y);
    end

    always_ff @(posedge i_clk) begin
        r_s1x <= w_sw ? w_a2x : w_a1x;  r_s1y <= w_sw ? w_a2y : w_a1y;
        r_e1x <= w_sw ? w_b2x : w_b1x;  r_e1y <= w_sw ? w_b2y : w_b1y;
        r_s2x <= w_sw ? w_a1x : w_a2x;  r_s2y <= w_sw ? w_a1y : w_a2y;
        r_e2x <= w_sw ? w_b1x : w_b2x;  r_e2y <= w_sw ? w_b1y : w_b2y;
    end

    // stage 2: direction vectors and start offset
    logic signed [DW-1:0] r_d1x, r_d1y, r_d2x, r_d2y, r_rx, r_ry;
    logic signed [CW-1:0] r2_s1x, r2_s1y, r2_s2x, r2_s2y;
    logic                 r2_lex;

    always_ff @(posedge i_clk) begin
        r_d1x  <= DW'(r_e1x) - DW'(r_s1x);
        r_d1y  <= DW'(r_e1y) - DW'(r_s1y);
        r_d2x  <= DW'(r_e2x) - DW'(r_s2x);
        r_d2y  <= DW'(r_e2y) - DW'(r_s2y);
        r_rx   <= DW'(r_s2x) - DW'(r_s1x);
        r_ry   <= DW'(r_s2y) - DW'(r_s1y);
        r2_lex <= lex_le(r_s2x, r_s2y, r_e1x, r_e1y);
        r2_s1x <= r_s1x; r2_s1y <= r_s1y; r2_s2x <= r_s2x; r2_s2y <= r_s2y;
    end

    // stage 3: cross product terms
    logic signed [PW-1:0] r_pda, r_pdb, r_pta, r_ptb, r_pua, r_pub;
    logic signed [DW-1:0] r3_d1x, r3_d1y;
    logic signed [CW-1:0] r3_s1x, r3_s1y, r3_s2x, r3_s2y;
    logic                 r3_lex;

    always_ff @(posedge i_clk) begin
        r_pda  <= r_d1x * r_d2y;
        r_pdb  <= r_d1y * r_d2x;
        r_pta  <= r_rx * r_d2y;
        r_ptb  <= r_ry * r_d2x;
        r_pua  <= r_rx * r_d1y;
        r_pub  <= r_ry * r_d1x;
        r3_d1x <= r_d1x; r3_d1y <= r_d1y;
        r3_s1x <= r2_s1x; r3_s1y <= r2_s1y; r3_s2x <= r2_s2x; r3_s2y <= r2_s2y;
        r3_lex <= r2_lex;
    end

    // stage 4: cross products
    logic signed [CRW-1:0] r_den, r_tn, r_un;
    logic signed [DW-1:0]  r4_d1x, r4_d1y;
    logic signed [CW-1:0]  r4_s1x, r4_s1y, r4_s2x, r4_s2y;
    logic                  r4_lex;

    always_ff @(posedge i_clk) begin
        r_den  <= CRW'(r_pda) - CRW'(r_pdb);
        r_tn   <= CRW'(r_pta) - CRW'(r_ptb);
        r_un   <= CRW'(r_pua) - CRW'(r_pub);
        r4_d1x <= r3_d1x; r4_d1y <= r3_d1y;
        r4_s1x <= r3_s1x; r4_s1y <= r3_s1y; r4_s2x <= r3_s2x; r4_s2y <= r3_s2y;
        r4_lex <= r3_lex;
    end

    // stage 5: sign normalize and classify
    logic signed [CRW-1:0] w_den_n, w_tn_n, w_un_n;
    logic                  w_par, w_col, w_inr;
    logic [RW-1:0]         r5_den;
    logic signed [CRW-1:0] r5_tn;
    logic                  r5_found, r5_overlap;
    logic signed [DW-1:0]  r5_d1x, r5_d1y;
    logic signed [CW-1:0]  r5_s1x, r5_s1y, r5_s2x, r5_s2y;

    always_comb begin
        w_den_n = r_den[CRW-1] ? -r_den : r_den;
        w_tn_n  = r_den[CRW-1] ? -r_tn  : r_tn;
        w_un_n  = r_den[CRW-1] ? -r_un  : r_un;
        w_par   = (r_den == '0);
        w_col   = w_par && (r_tn == '0) && (r_un == '0) && r4_lex;
        w_inr   = !w_tn_n[CRW-1] && (w_tn_n <= w_den_n) &&
                  !w_un_n[CRW-1] && (w_un_n <= w_den_n);
    end

    always_ff @(posedge i_clk) begin
        r5_den     <= RW'(w_den_n);
        r5_tn      <= w_tn_n;
        r5_found   <= w_par ? w_col : w_inr;
        r5_overlap <= w_col;
        r5_d1x <= r4_d1x; r5_d1y <= r4_d1y;
        r5_s1x <= r4_s1x; r5_s1y <= r4_s1y; r5_s2x <= r4_s2x; r5_s2y <= r4_s2y;
    end

    // stage 6: numerators
    logic signed [NW-1:0] r_numx, r_numy;
    logic [RW-1:0]        r6_den;
    t_side                r6_side;

    always_ff @(posedge i_clk) begin
        r_numx  <= r5_d1x * r5_tn;
        r_numy  <= r5_d1y * r5_tn;
        r6_den  <= (r5_den == '0) ? RW'(1) : r5_den;
        r6_side <= '{found: r5_found, overlap: r5_overlap, neg_x: 1'b0, neg_y: 1'b0,
                     s1x: r5_s1x, s1y: r5_s1y, s2x: r5_s2x, s2y: r5_s2y};
    end

    // stage 7: magnitudes for the dividers
    logic [NW-1:0] r_magx, r_magy;
    logic [RW-1:0] r7_den;
    t_side         r7_side;

    always_ff @(posedge i_clk) begin
        r_magx  <= r_numx[NW-1] ? NW'(-r_numx) : NW'(r_numx);
        r_magy  <= r_numy[NW-1] ? NW'(-r_numy) : NW'(r_numy);
        r7_den  <= r6_den;
        r7_side <= '{found: r6_side.found, overlap: r6_side.overlap,
                     neg_x: r_numx[NW-1], neg_y: r_numy[NW-1],
                     s1x: r6_side.s1x, s1y: r6_side.s1y,
                     s2x: r6_side.s2x, s2y: r6_side.s2y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[5:0], start};
        end
    end

    // dividers
    logic [QW-1:0] w_qx, w_qy;
    logic          w_nzx, w_nzy;

    segi_div u_div_x (
        .i_clk    (i_clk),
        .i_mag    (r_magx),
        .i_den    (r7_den),
        .o_quot   (w_qx),
        .o_rem_nz (w_nzx)
    );

    segi_div u_div_y (
        .i_clk    (i_clk),
        .i_mag    (r_magy),
        .i_den    (r7_den),
        .o_quot   (w_qy),
        .o_rem_nz (w_nzy)
    );

    // sideband delay matching the divider depth
    t_side r_side [QW];
    logic  r_sv   [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_side
            always_ff @(posedge i_clk) begin
                r_side[k] <= (k == 0) ? r7_side : r_side[(k == 0) ? 0 : k-1];
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sv[k] <= 1'b0;
                end else begin
                    r_sv[k] <= (k == 0) ? r_v[6] : r_sv[(k == 0) ? 0 : k-1];
                end
            end
        end
    endgenerate

    // final assembly: floor correction, add start point, select result
    t_side                w_sd;
    logic signed [SUMW-1:0] w_qfx, w_qfy, w_px, w_py;

    always_comb begin
        w_sd  = r_side[QW-1];
        w_qfx = w_sd.neg_x ? -SUMW'(w_qx) - SUMW'(w_nzx) : SUMW'(w_qx);
        w_qfy = w_sd.neg_y ? -SUMW'(w_qy) - SUMW'(w_nzy) : SUMW'(w_qy);
        if (!w_sd.found) begin
            w_px = '0;
            w_py = '0;
        end else if (w_sd.overlap) begin
            w_px = SUMW'(w_sd.s2x) <<< FRAC_BITS;
            w_py = SUMW'(w_sd.s2y) <<< FRAC_BITS;
        end else begin
            w_px = (SUMW'(w_sd.s1x) <<< FRAC_BITS) + w_qfx;
            w_py = (SUMW'(w_sd.s1y) <<< FRAC_BITS) + w_qfy;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_sv[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_found   <= w_sd.found;
        o_overlap <= w_sd.overlap;
        o_point_x <= w_px[OUT_WIDTH-1:0];
        o_point_y <= w_py[OUT_WIDTH-1:0];
    end

endmodule

### test/tb_top.sv
// self-checking testbench for the segment intersection pipeline
module tb_top;

    localparam int CW = segi_pkg::COORD_WIDTH;
    localparam int FB = segi_pkg::FRAC_BITS;
    localparam int OW = segi_pkg::OUT_WIDTH;
    localparam int N_RANDOM = 1200;
    localparam int DRAIN_CYCLES = 60;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct {
        coord_t c [8];
    } seg_pair_t;

    typedef struct {
        logic          found;
        logic          overlap;
        logic [OW-1:0] px;
        logic [OW-1:0] py;
    } meet_t;

    typedef struct {
        seg_pair_t pair;
        logic      typed;
        meet_t     want;
    } vector_t;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    coord_t seg [8];
    logic   o_done, o_found, o_overlap;
    logic signed [OW-1:0] o_point_x, o_point_y;

    meet_t pending_meets [$];
    int    n_fail = 0;
    int    n_words = 0;
    int    n_hits = 0;
    int    n_overlaps = 0;

    initial for (int k = 0; k < 8; k++) seg[k] = '0;

    always #2 i_clk = ~i_clk;

    segment_intersection_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_seg1_start_x (seg[0]),
        .i_seg1_start_y (seg[1]),
        .i_seg1_end_x   (seg[2]),
        .i_seg1_end_y   (seg[3]),
        .i_seg2_start_x (seg[4]),
        .i_seg2_start_y (seg[5]),
        .i_seg2_end_x   (seg[6]),
        .i_seg2_end_y   (seg[7]),
        .o_done         (o_done),
        .o_found        (o_found),
        .o_overlap      (o_overlap),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y)
    );

    // lexicographic order on points: x first, y breaks ties
    function automatic bit pt_le(longint ax, longint ay, longint bx, longint by);
        return (ax < bx) || (ax == bx && ay <= by);
    endfunction

    // floor((base + num/den) * 2^FB) masked to the output width, den > 0
    function automatic logic [OW-1:0] floor_fixed(longint base, longint num, longint den);
        longint q;
        longint r;
        longint unsigned frac;
        longint unsigned whole;
        q = num / den;
        r = num % den;
        if (r < 0) begin
            q -= 1;
            r += den;
        end
        frac  = (longint'(r) << FB) / den;
        whole = longint'(base + q) << FB;
        return OW'(whole + frac);
    endfunction

    // meeting point of two segments by exact cross products
    function automatic meet_t predict_meet(seg_pair_t p);
        meet_t  m;
        longint s1x, s1y, e1x, e1y, s2x, s2y, e2x, e2y, tmp;
        longint d1x, d1y, d2x, d2y, rx, ry, den, tn, un;
        s1x = p.c[0]; s1y = p.c[1]; e1x = p.c[2]; e1y = p.c[3];
        s2x = p.c[4]; s2y = p.c[5]; e2x = p.c[6]; e2y = p.c[7];
        m = '{1'b0, 1'b0, '0, '0};
        // put each segment in order, then the pair
        if (!pt_le(s1x, s1y, e1x, e1y)) begin
            tmp = s1x; s1x = e1x; e1x = tmp;
            tmp = s1y; s1y = e1y; e1y = tmp;
        end
        if (!pt_le(s2x, s2y, e2x, e2y)) begin
            tmp = s2x; s2x = e2x; e2x = tmp;
            tmp = s2y; s2y = e2y; e2y = tmp;
        end
        if (!pt_le(s1x, s1y, s2x, s2y)) begin
            tmp = s1x; s1x = s2x; s2x = tmp;
            tmp = s1y; s1y = s2y; s2y = tmp;
            tmp = e1x; e1x = e2x; e2x = tmp;
            tmp = e1y; e1y = e2y; e2y = tmp;
        end
        d1x = e1x - s1x; d1y = e1y - s1y;
        d2x = e2x - s2x; d2y = e2y - s2y;
        rx  = s2x - s1x; ry  = s2y - s1y;
        den = d1x * d2y - d1y * d2x;
        // parallel: only collinear sharing points counts
        if (den == 0) begin
            if (d1x * ry - d1y * rx == 0 && d2x * ry - d2y * rx == 0 &&
                pt_le(s2x, s2y, e1x, e1y)) begin
                m.found   = 1'b1;
                m.overlap = 1'b1;
                m.px      = OW'(s2x << FB);
                m.py      = OW'(s2y << FB);
            end
            return m;
        end
        tn = rx * d2y - ry * d2x;
        un = rx * d1y - ry * d1x;
        if (den < 0) begin
            den = -den;
            tn  = -tn;
            un  = -un;
        end
        if (tn < 0 || tn > den || un < 0 || un > den) return m;
        m.found = 1'b1;
        m.px    = floor_fixed(s1x, d1x * tn, den);
        m.py    = floor_fixed(s1y, d1y * tn, den);
        return m;
    endfunction

    // result checker first, then record the word accepted at this edge
    always @(posedge i_clk) begin
        meet_t w;
        if (i_rst_n && o_done) begin
            n_words++;
            if (pending_meets.size() == 0) begin
                $error("result word with nothing expected");
                n_fail++;
            end else begin
                w = pending_meets.pop_front();
                if (o_found !== w.found) begin
                    $error("found: expected %0d actual %0d", w.found, o_found);
                    n_fail++;
                end
                if (o_overlap !== w.overlap) begin
                    $error("overlap: expected %0d actual %0d", w.overlap, o_overlap);
                    n_fail++;
                end
                if (o_point_x !== w.px) begin
                    $error("point_x: expected %h actual %h", w.px, o_point_x);
                    n_fail++;
                end
                if (o_point_y !== w.py) begin
                    $error("point_y: expected %h actual %h", w.py, o_point_y);
                    n_fail++;
                end
                if (w.found) n_hits++;
                if (w.overlap) n_overlaps++;
            end
        end
        if (i_rst_n && start && !busy) begin
            seg_pair_t p;
            for (int k = 0; k < 8; k++) p.c[k] = seg[k];
            pending_meets.push_back(predict_meet(p));
        end
    end

    // present one word and hold it until accepted
    task automatic send_pair(seg_pair_t p);
        @(negedge i_clk);
        for (int k = 0; k < 8; k++) seg[k] = p.c[k];
        start = 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    task automatic wait_drained();
        idle_cycles(1);
        while (pending_meets.size() != 0) @(negedge i_clk);
    endtask

    // typed row against the predictor, field by field
    task automatic check_typed(int row, meet_t want, meet_t got);
        if (got.found !== want.found) begin
            $error("row %0d found: expected %0d actual %0d", row, want.found, got.found);
            n_fail++;
        end
        if (got.overlap !== want.overlap) begin
            $error("row %0d overlap: expected %0d actual %0d", row, want.overlap, got.overlap);
            n_fail++;
        end
        if (got.px !== want.px) begin
            $error("row %0d point_x: expected %h actual %h", row, want.px, got.px);
            n_fail++;
        end
        if (got.py !== want.py) begin
            $error("row %0d point_y: expected %h actual %h", row, want.py, got.py);
            n_fail++;
        end
    endtask

    function automatic seg_pair_t mk(int a, int b, int c, int d, int e, int f, int g, int h);
        seg_pair_t p;
        p.c = '{coord_t'(a), coord_t'(b), coord_t'(c), coord_t'(d),
                coord_t'(e), coord_t'(f), coord_t'(g), coord_t'(h)};
        return p;
    endfunction

    // random pair: wide, small grid, collinear or extreme corners
    function automatic seg_pair_t random_pair();
        seg_pair_t p;
        int bx, by, dx, dy;
        case ($urandom_range(0, 3))
            0: for (int k = 0; k < 8; k++) p.c[k] = coord_t'($urandom);
            1: for (int k = 0; k < 8; k++) p.c[k] = coord_t'($urandom_range(0, 16) - 8);
            2: begin
                // points along one line through a random base
                bx = $urandom_range(0, 2000) - 1000;
                by = $urandom_range(0, 2000) - 1000;
                dx = $urandom_range(0, 8) - 4;
                dy = $urandom_range(0, 8) - 4;
                for (int k = 0; k < 4; k++) begin
                    int t;
                    t = $urandom_range(0, 40) - 20;
                    p.c[2*k]   = coord_t'(bx + t * dx);
                    p.c[2*k+1] = coord_t'(by + t * dy);
                end
            end
            default: for (int k = 0; k < 8; k++)
                case ($urandom_range(0, 3))
                    0: p.c[k] = coord_t'(-32768);
                    1: p.c[k] = coord_t'(32767);
                    2: p.c[k] = '0;
                    default: p.c[k] = coord_t'($urandom);
                endcase
        endcase
        return p;
    endfunction

    vector_t directed [$];

    // stimulus
    initial begin
        int burst;
        directed = '{
            // crossing x at the origin
            '{mk(-10, -10, 10, 10, -10, 10, 10, -10), 1'b1, '{1, 0, 0, 0}},
            // parallel, distinct lines
            '{mk(0, 0, 10, 0, 0, 1, 10, 1), 1'b1, '{0, 0, 0, 0}},
            // collinear overlap gives the later start
            '{mk(0, 0, 10, 0, 5, 0, 20, 0), 1'b1, '{1, 1, 32'h0005_0000, 0}},
            // collinear disjoint
            '{mk(0, 0, 1, 0, 5, 0, 6, 0), 1'b1, '{0, 0, 0, 0}},
            // vertical against horizontal
            '{mk(3, -5, 3, 5, -5, 2, 5, 2), 1'b1, '{1, 0, 32'h0003_0000, 32'h0002_0000}},
            // degenerate segment on the other line
            '{mk(2, 2, 2, 2, 0, 0, 4, 4), 1'b1, '{1, 1, 32'h0002_0000, 32'h0002_0000}},
            // half-unit meeting point
            '{mk(0, 0, 1, 1, 0, 1, 1, 0), 1'b1, '{1, 0, 32'h0000_8000, 32'h0000_8000}},
            // collinear touching at one end only
            '{mk(0, 0, 3, 3, 3, 3, 6, 6), 1'b1, '{1, 1, 32'h0003_0000, 32'h0003_0000}},
            // both segments degenerate and apart
            '{mk(1, 1, 1, 1, 2, 2, 2, 2), 1'b1, '{0, 0, 0, 0}},
            // extreme diagonals
            '{mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768), 1'b0, '{0, 0, 0, 0}},
            // reversed endpoints and swapped segments
            '{mk(10, 10, -10, -10, 7, -3, -7, 3), 1'b0, '{0, 0, 0, 0}},
            // equal start x, y breaks the tie
            '{mk(0, 5, 4, 1, 0, -5, 4, 9), 1'b0, '{0, 0, 0, 0}},
            // miss just beyond an end
            '{mk(0, 0, 1, 1, 3, 0, 3, 9), 1'b1, '{0, 0, 0, 0}},
            // negative fractional meeting point
            '{mk(-3, -1, 0, 0, -3, 0, 0, -1), 1'b0, '{0, 0, 0, 0}},
            // all-ones and all-zero corners
            '{mk(-1, -1, 32767, -32768, 0, 0, -32768, 32767), 1'b0, '{0, 0, 0, 0}}
        };
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[i]) begin
            send_pair(directed[i].pair);
            // typed rows must agree with the predictor too
            if (directed[i].typed) check_typed(i, directed[i].want, predict_meet(directed[i].pair));
        end
        // full drain before the random part
        wait_drained();

        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < N_RANDOM; b++, n++) send_pair(random_pair());
            case ($urandom_range(0, 9))
                0: wait_drained();
                1, 2, 3: ;
                default: idle_cycles($urandom_range(1, 8));
            endcase
        end
        idle_cycles(1);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d result words checked: %0d meeting points, %0d collinear overlaps",
                 n_words, n_hits, n_overlaps);
        if (n_fail == 0 && pending_meets.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #400000;
        $display("timeout with %0d words outstanding", pending_meets.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### segment_intersection_top.f
hdl/segi_pkg.sv
hdl/segi_div.sv
hdl/segment_intersection_top.sv
test/tb_top.sv
